// ===== sv/mfd_pkg.sv =====
// shared types, constants and job tables of the meter frame decoder
`timescale 1ns / 1ps

package mfd_pkg;

    // frame layout
    localparam int DATA_BYTES = 22;
    localparam int POS_W      = 5;
    localparam int STAGE_LEN  = 16;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int RAW_W    = 24;
    localparam int TOTAL_W  = 48;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared unit widths
    localparam int ACC_W  = 64;
    localparam int STEP_W = 6;
    localparam int MULT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_READ_COMMAND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_CAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_DEFAULT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CONSTANT  = 3'd5;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] READ_COMMAND_RST = 8'd88;
    localparam logic [RAW_W-1:0]  SCALE_ONE        = 24'd1;

    // shared unit operations
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_MUL,
        OP_ALIGN,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        unit_op_t          op;
        logic              mul_bit;
        logic [STEP_W-1:0] align;
    } unit_ctrl_t;

    // scaling jobs, run in this order
    typedef enum logic [1:0] {
        JOB_CURRENT,
        JOB_VOLTAGE,
        JOB_POWER,
        JOB_ENERGY
    } job_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_command;
        logic [RAW_W-1:0]  current_scale;
        logic [RAW_W-1:0]  voltage_cal_scale;
        logic [RAW_W-1:0]  voltage_default_scale;
        logic [RAW_W-1:0]  power_scale;
        logic [RAW_W-1:0]  pulse_constant;
    } cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0]   current_raw;
        logic [RAW_W-1:0]   voltage_raw;
        logic [RAW_W-1:0]   power_raw;
        logic [TOTAL_W-1:0] pulse_total;
    } meas_t;

    typedef struct packed {
        logic chk;
        logic good;
    } frame_evt_t;

    typedef struct packed {
        logic [OUT_W-1:0] current_milli;
        logic [OUT_W-1:0] voltage_centi;
        logic [RAW_W-1:0] power_magnitude;
        logic [OUT_W-1:0] energy_units;
    } result_t;

    // constant multiplier of each job
    function automatic logic [MULT_W-1:0] job_mult(input job_t job);
        case (job)
            JOB_CURRENT: job_mult = 16'd1000;
            JOB_VOLTAGE: job_mult = 16'd100;
            JOB_POWER:   job_mult = 16'd1;
            JOB_ENERGY:  job_mult = 16'd10000;
            default:     job_mult = 16'd1;
        endcase
    endfunction

    // significant bits of the multiplier, one multiply step each
    function automatic logic [STEP_W-1:0] job_mul_steps(input job_t job);
        case (job)
            JOB_CURRENT: job_mul_steps = 6'd10;
            JOB_VOLTAGE: job_mul_steps = 6'd7;
            JOB_POWER:   job_mul_steps = 6'd1;
            JOB_ENERGY:  job_mul_steps = 6'd14;
            default:     job_mul_steps = 6'd1;
        endcase
    endfunction

    // dividend width after the multiply, one divide step each
    function automatic logic [STEP_W-1:0] job_div_steps(input job_t job);
        case (job)
            JOB_CURRENT: job_div_steps = 6'd34;
            JOB_VOLTAGE: job_div_steps = 6'd31;
            JOB_POWER:   job_div_steps = 6'd24;
            JOB_ENERGY:  job_div_steps = 6'd62;
            default:     job_div_steps = 6'd62;
        endcase
    endfunction

endpackage

// ===== sv/mfd_if.sv =====
// handshake channels of the meter frame decoder
`timescale 1ns / 1ps

interface mfd_in_if;
    logic                             valid;
    logic                             ready;
    logic [mfd_pkg::BYTE_W-1:0]       rx_byte;
    logic                             frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mfd_out_if;
    logic                             valid;
    logic                             ready;
    logic                             frame_ok;
    logic [mfd_pkg::OUT_W-1:0]        current_milli;
    logic [mfd_pkg::OUT_W-1:0]        voltage_centi;
    logic [mfd_pkg::RAW_W-1:0]        power_magnitude;
    logic [mfd_pkg::TOTAL_W-1:0]      pulse_total;
    logic [mfd_pkg::OUT_W-1:0]        energy_units;

    modport source (output valid, output frame_ok, output current_milli,
                    output voltage_centi, output power_magnitude, output pulse_total,
                    output energy_units, input ready);
    modport sink   (input valid, input frame_ok, input current_milli,
                    input voltage_centi, input power_magnitude, input pulse_total,
                    input energy_units, output ready);
endinterface

interface mfd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mfd_pkg::CFG_IDX_W-1:0]    index;
    logic [mfd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/mfd_frame.sv =====
// byte framing, checksum and field capture of the meter frame decoder
`timescale 1ns / 1ps

module mfd_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [mfd_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                          frame_start,
    input  logic [mfd_pkg::BYTE_W-1:0]    read_command,
    output mfd_pkg::frame_evt_t           evt,
    output logic                          expect_chk,
    output mfd_pkg::meas_t                meas
);

    logic [mfd_pkg::POS_W-1:0]  pos_reg;
    logic                       in_frame_reg;
    logic [mfd_pkg::BYTE_W-1:0] sum_reg;
    logic [mfd_pkg::BYTE_W-1:0] stage_reg [1:mfd_pkg::STAGE_LEN-1];
    mfd_pkg::meas_t             meas_reg;
    logic                       chk_good;

    // next byte closes the frame
    assign expect_chk = in_frame_reg && (pos_reg == mfd_pkg::POS_W'(mfd_pkg::DATA_BYTES));
    assign chk_good   = (~sum_reg) == rx_byte;

    assign evt.chk  = accept && !frame_start && expect_chk;
    assign evt.good = chk_good;
    assign meas     = meas_reg;

    // framing, running sum and commit of good frames
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            sum_reg      <= '0;
            meas_reg     <= '0;
        end
        else if (accept)
        begin
            if (frame_start)
            begin
                in_frame_reg <= 1'b1;
                pos_reg      <= mfd_pkg::POS_W'(1);
                sum_reg      <= read_command + rx_byte;
            end
            else if (in_frame_reg)
            begin
                if (expect_chk)
                begin
                    in_frame_reg <= 1'b0;
                    pos_reg      <= '0;
                    if (chk_good)
                    begin
                        meas_reg.current_raw <= {stage_reg[3], stage_reg[2], stage_reg[1]};
                        meas_reg.voltage_raw <= {stage_reg[6], stage_reg[5], stage_reg[4]};
                        meas_reg.power_raw   <= {stage_reg[12], stage_reg[11], stage_reg[10]};
                        meas_reg.pulse_total <= meas_reg.pulse_total +
                            {24'd0, stage_reg[15], stage_reg[14], stage_reg[13]};
                    end
                end
                else
                begin
                    sum_reg <= sum_reg + rx_byte;
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    // staging copy of the leading data bytes
    always_ff @(posedge clk)
    begin
        if (accept && !frame_start && in_frame_reg && !expect_chk &&
            (pos_reg < mfd_pkg::POS_W'(mfd_pkg::STAGE_LEN)))
        begin
            stage_reg[pos_reg[3:0]] <= rx_byte;
        end
    end

endmodule

// ===== sv/mfd_unit.sv =====
// shared shift-add multiply and restoring divide unit
`timescale 1ns / 1ps

module mfd_unit (
    input  logic                          clk,
    input  mfd_pkg::unit_ctrl_t           ctrl,
    input  logic [mfd_pkg::TOTAL_W-1:0]   operand,
    input  logic [mfd_pkg::RAW_W-1:0]     divisor,
    output logic [mfd_pkg::ACC_W-1:0]     acc
);

    logic [mfd_pkg::ACC_W-1:0] acc_reg;
    logic [mfd_pkg::ACC_W-1:0] acc_next;
    logic [mfd_pkg::RAW_W-1:0] rem_reg;
    logic [mfd_pkg::RAW_W-1:0] rem_next;
    logic [mfd_pkg::RAW_W:0]   trial;
    logic [mfd_pkg::RAW_W+1:0] diff;
    logic [mfd_pkg::ACC_W-1:0] addend;

    assign acc    = acc_reg;
    assign trial  = {rem_reg, acc_reg[mfd_pkg::ACC_W-1]};
    assign diff   = {1'b0, trial} - {2'b00, divisor};
    assign addend = ctrl.mul_bit ? {{(mfd_pkg::ACC_W-mfd_pkg::TOTAL_W){1'b0}}, operand} : '0;

    // one multiply or divide step per cycle
    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        case (ctrl.op)
            mfd_pkg::OP_HOLD:
            begin
                acc_next = acc_reg;
            end
            mfd_pkg::OP_CLEAR:
            begin
                acc_next = '0;
                rem_next = '0;
            end
            mfd_pkg::OP_MUL:
            begin
                acc_next = {acc_reg[mfd_pkg::ACC_W-2:0], 1'b0} + addend;
            end
            mfd_pkg::OP_ALIGN:
            begin
                acc_next = acc_reg << ctrl.align;
                rem_next = '0;
            end
            mfd_pkg::OP_DIV:
            begin
                if (diff[mfd_pkg::RAW_W+1])
                begin
                    rem_next = trial[mfd_pkg::RAW_W-1:0];
                    acc_next = {acc_reg[mfd_pkg::ACC_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = diff[mfd_pkg::RAW_W-1:0];
                    acc_next = {acc_reg[mfd_pkg::ACC_W-2:0], 1'b1};
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== sv/mfd_seq.sv =====
// sequencer that runs the four scaling jobs on the shared unit
`timescale 1ns / 1ps

module mfd_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mfd_pkg::cfg_t                 cfg,
    input  mfd_pkg::meas_t                meas,
    input  logic [mfd_pkg::ACC_W-1:0]     acc,
    output mfd_pkg::unit_ctrl_t           ctrl,
    output logic [mfd_pkg::TOTAL_W-1:0]   operand,
    output logic [mfd_pkg::RAW_W-1:0]     divisor,
    output logic                          busy,
    output logic                          done,
    output mfd_pkg::result_t              res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ALIGN,
        S_DIV,
        S_STORE
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    mfd_pkg::job_t                job_reg;
    mfd_pkg::job_t                job_next;
    mfd_pkg::job_t                job_after;
    logic [mfd_pkg::STEP_W-1:0]   step_reg;
    logic [mfd_pkg::STEP_W-1:0]   step_next;
    logic                         done_reg;
    logic                         done_next;
    mfd_pkg::result_t             res_reg;
    mfd_pkg::result_t             res_next;
    logic [mfd_pkg::MULT_W-1:0]   mult;
    logic [mfd_pkg::RAW_W-1:0]    magnitude;
    logic [mfd_pkg::OUT_W-1:0]    quot_sat;

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign res  = res_reg;

    assign job_after = mfd_pkg::job_t'(job_reg + 1'b1);
    assign mult      = mfd_pkg::job_mult(job_reg);
    assign magnitude = meas.power_raw[mfd_pkg::RAW_W-1] ? (~meas.power_raw + 1'b1)
                                                        : meas.power_raw;
    assign quot_sat  = (acc[mfd_pkg::ACC_W-1:mfd_pkg::OUT_W] != '0) ? '1
                                                                     : acc[mfd_pkg::OUT_W-1:0];

    // operand and divisor of the running job
    always_comb
    begin
        case (job_reg)
            mfd_pkg::JOB_CURRENT:
            begin
                operand = {24'd0, meas.current_raw};
                divisor = (cfg.current_scale == '0) ? mfd_pkg::SCALE_ONE : cfg.current_scale;
            end
            mfd_pkg::JOB_VOLTAGE:
            begin
                operand = {24'd0, meas.voltage_raw};
                if (cfg.voltage_cal_scale != '0)
                    divisor = cfg.voltage_cal_scale;
                else if (cfg.voltage_default_scale != '0)
                    divisor = cfg.voltage_default_scale;
                else
                    divisor = mfd_pkg::SCALE_ONE;
            end
            mfd_pkg::JOB_POWER:
            begin
                operand = {24'd0, magnitude};
                divisor = (cfg.power_scale == '0) ? mfd_pkg::SCALE_ONE : cfg.power_scale;
            end
            mfd_pkg::JOB_ENERGY:
            begin
                operand = meas.pulse_total;
                divisor = (cfg.pulse_constant == '0) ? mfd_pkg::SCALE_ONE : cfg.pulse_constant;
            end
            default:
            begin
                operand = meas.pulse_total;
                divisor = mfd_pkg::SCALE_ONE;
            end
        endcase
    end

    // job sequencing
    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        ctrl.op      = mfd_pkg::OP_HOLD;
        ctrl.mul_bit = mult[step_reg[3:0]];
        ctrl.align   = mfd_pkg::STEP_W'(mfd_pkg::ACC_W) - mfd_pkg::job_div_steps(job_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op    = mfd_pkg::OP_CLEAR;
                    job_next   = mfd_pkg::JOB_CURRENT;
                    step_next  = mfd_pkg::job_mul_steps(mfd_pkg::JOB_CURRENT) - 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctrl.op = mfd_pkg::OP_MUL;
                if (step_reg == '0)
                    state_next = S_ALIGN;
                else
                    step_next = step_reg - 1'b1;
            end
            S_ALIGN:
            begin
                ctrl.op    = mfd_pkg::OP_ALIGN;
                step_next  = mfd_pkg::job_div_steps(job_reg) - 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctrl.op = mfd_pkg::OP_DIV;
                if (step_reg == '0)
                    state_next = S_STORE;
                else
                    step_next = step_reg - 1'b1;
            end
            S_STORE:
            begin
                ctrl.op = mfd_pkg::OP_CLEAR;
                case (job_reg)
                    mfd_pkg::JOB_CURRENT: res_next.current_milli   = quot_sat;
                    mfd_pkg::JOB_VOLTAGE: res_next.voltage_centi   = quot_sat;
                    mfd_pkg::JOB_POWER:   res_next.power_magnitude = acc[mfd_pkg::RAW_W-1:0];
                    mfd_pkg::JOB_ENERGY:  res_next.energy_units    = quot_sat;
                    default:              res_next                 = res_reg;
                endcase
                if (job_reg == mfd_pkg::JOB_ENERGY)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    job_next   = job_after;
                    step_next  = mfd_pkg::job_mul_steps(job_after) - 1'b1;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= mfd_pkg::JOB_CURRENT;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

endmodule

// ===== sv/meter_frame_decoder.sv =====
// top level of the meter frame decoder: config registers, framing, scaling, result register
`timescale 1ns / 1ps
//
// channel  direction  transaction
// in_ch    sink       one response byte with its frame-start mark
// out_ch   source     one decoded result per checksum byte
// cfg      sink       one register write (index, data), always ready
//
// a byte that closes no frame, and a checksum byte that fails, starts no work on the shared unit
// a good checksum byte starts work on the shared 64-bit unit:
// bit-serial constant multiply, align, then restoring divide for each of four values
// the result register loads in the cycle after that work ends
// in_ch.ready stays low until then and while a result waits ahead of a checksum byte
// rst_n clears framing, totals and configuration to their reset values at once

module meter_frame_decoder (
    input  logic       clk,
    input  logic       rst_n,
    mfd_in_if.sink     in_ch,
    mfd_out_if.source  out_ch,
    mfd_cfg_if.sink    cfg
);

    mfd_pkg::cfg_t                  cfg_reg;
    mfd_pkg::frame_evt_t            evt;
    mfd_pkg::meas_t                 meas;
    mfd_pkg::unit_ctrl_t            ctrl;
    mfd_pkg::result_t               res;
    logic                           expect_chk;
    logic                           accept;
    logic                           busy;
    logic                           done;
    logic                           start;
    logic [mfd_pkg::TOTAL_W-1:0]    operand;
    logic [mfd_pkg::RAW_W-1:0]      divisor;
    logic [mfd_pkg::ACC_W-1:0]      acc;

    logic                           out_valid_reg;
    logic                           frame_ok_reg;
    mfd_pkg::result_t               out_res_reg;
    logic [mfd_pkg::TOTAL_W-1:0]    pulse_total_reg;

    // input handshake
    assign in_ch.ready = !busy && !(expect_chk && out_valid_reg);
    assign accept      = in_ch.valid && in_ch.ready;
    assign start       = evt.chk && evt.good;
    assign cfg.ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_command          <= mfd_pkg::READ_COMMAND_RST;
            cfg_reg.current_scale         <= mfd_pkg::SCALE_ONE;
            cfg_reg.voltage_cal_scale     <= '0;
            cfg_reg.voltage_default_scale <= mfd_pkg::SCALE_ONE;
            cfg_reg.power_scale           <= mfd_pkg::SCALE_ONE;
            cfg_reg.pulse_constant        <= mfd_pkg::SCALE_ONE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mfd_pkg::REG_READ_COMMAND:    cfg_reg.read_command <= cfg.data[7:0];
                mfd_pkg::REG_CURRENT_SCALE:   cfg_reg.current_scale <= cfg.data;
                mfd_pkg::REG_VOLTAGE_CAL:     cfg_reg.voltage_cal_scale <= cfg.data;
                mfd_pkg::REG_VOLTAGE_DEFAULT: cfg_reg.voltage_default_scale <= cfg.data;
                mfd_pkg::REG_POWER_SCALE:     cfg_reg.power_scale <= cfg.data;
                mfd_pkg::REG_PULSE_CONSTANT:  cfg_reg.pulse_constant <= cfg.data;
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    mfd_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (in_ch.rx_byte),
        .frame_start  (in_ch.frame_start),
        .read_command (cfg_reg.read_command),
        .evt          (evt),
        .expect_chk   (expect_chk),
        .meas         (meas)
    );

    mfd_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cfg     (cfg_reg),
        .meas    (meas),
        .acc     (acc),
        .ctrl    (ctrl),
        .operand (operand),
        .divisor (divisor),
        .busy    (busy),
        .done    (done),
        .res     (res)
    );

    mfd_unit u_unit (
        .clk     (clk),
        .ctrl    (ctrl),
        .operand (operand),
        .divisor (divisor),
        .acc     (acc)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            frame_ok_reg    <= 1'b0;
            out_res_reg     <= '0;
            pulse_total_reg <= '0;
        end
        else if (done)
        begin
            out_valid_reg   <= 1'b1;
            frame_ok_reg    <= 1'b1;
            out_res_reg     <= res;
            pulse_total_reg <= meas.pulse_total;
        end
        else if (evt.chk && !evt.good)
        begin
            out_valid_reg   <= 1'b1;
            frame_ok_reg    <= 1'b0;
            out_res_reg     <= '0;
            pulse_total_reg <= '0;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.frame_ok        = frame_ok_reg;
    assign out_ch.current_milli   = out_res_reg.current_milli;
    assign out_ch.voltage_centi   = out_res_reg.voltage_centi;
    assign out_ch.power_magnitude = out_res_reg.power_magnitude;
    assign out_ch.pulse_total     = pulse_total_reg;
    assign out_ch.energy_units    = out_res_reg.energy_units;

endmodule
